[hdl/s2i_pkg.sv]
// Shared types and constants for the string to integer parser.
`timescale 1ns / 1ps
package s2i_pkg;

    localparam int DEF_MAX_LEN = 4096;

    localparam int CHAR_W  = 21;
    localparam int RADIX_W = 6;
    localparam int VAL_W   = 64;
    localparam int END_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the incoming item
        logic step;   // apply one character to the parse state
        logic calc;   // form the raw result
        logic emit;   // clamp, load the output register, clear the string state
    } s2i_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last;
        logic first;
    } s2i_status_t;

endpackage

[hdl/s2i_ctrl.sv]
// Controller state machine for the string to integer parser.
`timescale 1ns / 1ps
module s2i_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  s2i_pkg::s2i_status_t status,
    output s2i_pkg::s2i_cmd_t    cmd
);
    import s2i_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FIN1 = 4'b0100,
        S_FIN2 = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.step   = 1'b1;
                state_next = status.last ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                cmd.calc   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.emit = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/s2i_dp.sv]
// Datapath of the string to integer parser: registers, parse state, accumulator, result.
`timescale 1ns / 1ps
module s2i_dp #(
    parameter int MAX_LEN = s2i_pkg::DEF_MAX_LEN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [s2i_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s2i_pkg::VAL_W-1:0]      cfg_data,
    input  logic [s2i_pkg::CHAR_W-1:0]     char_in,
    input  logic                           last_in,
    input  s2i_pkg::s2i_cmd_t              cmd,
    output s2i_pkg::s2i_status_t           status,
    output logic [s2i_pkg::VAL_W-1:0]      value,
    output logic                           range_error,
    output logic [s2i_pkg::END_W-1:0]      end_position
);
    import s2i_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = VAL_W + RADIX_W + 1;

    localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 21'h30;
    localparam logic [CHAR_W-1:0] CH_LX    = 21'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 21'h58;
    localparam logic [CHAR_W-1:0] CH_LB    = 21'h62;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_2   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_8   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_10  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_16  = 6'd16;
    localparam logic [VAL_W-1:0] SIGN_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] SIGN_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [2:0] {
        PH_WS      = 3'd0,
        PH_SIGN    = 3'd1,
        PH_PREFIX  = 3'd2,
        PH_ZERO    = 3'd3,
        PH_DIGITS  = 3'd4,
        PH_DONE    = 3'd5,
        PH_INVALID = 3'd6
    } phase_t;

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        logic w;
        w = (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 || c == 21'hA0
            || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028
            || c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000;
        return w;
    endfunction

    // Digit value of c; ok is low when c is not a digit below the radix.
    function automatic logic [RADIX_W:0] digit_of(input logic [CHAR_W-1:0] c,
                                                  input logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0] d;
        logic               ok;
        d  = '0;
        ok = 1'b0;
        if (c >= 21'h30 && c <= 21'h39)
        begin
            d  = RADIX_W'(c - 21'h30);
            ok = 1'b1;
        end
        else if (c >= 21'h41 && c <= 21'h5A)
        begin
            d  = RADIX_W'(c - 21'h41 + 21'd10);
            ok = 1'b1;
        end
        else if (c >= 21'h61 && c <= 21'h7A)
        begin
            d  = RADIX_W'(c - 21'h61 + 21'd10);
            ok = 1'b1;
        end
        return {ok && (d < radix), d};
    endfunction

    // Configuration registers
    logic [RADIX_W-1:0] radix_set_reg;
    logic [VAL_W-1:0]   upper_reg;
    logic [VAL_W-1:0]   lower_reg;
    logic               signed_reg;

    // Input item
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    // Per-string parse state
    phase_t             phase_reg, phase_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [VAL_W-1:0]   elim_reg, elim_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   asp_reg, asp_next;
    logic [POS_W-1:0]   stop_reg, stop_next;
    logic               ovf_reg, ovf_next;
    logic               stopped_reg, stopped_next;

    // acc_reg * radix_reg, refreshed every cycle
    logic [VAL_W+RADIX_W-1:0] prod_reg;

    // Raw result
    logic [VAL_W-1:0]   raw_reg;
    logic               raw_err_reg;
    logic [POS_W-1:0]   raw_end_reg;
    logic               raw_end_zero_reg;

    // Output register
    logic [VAL_W-1:0]   value_reg, value_next;
    logic               err_reg, err_next;
    logic [END_W-1:0]   end_reg, end_next;

    logic               first;
    logic               used;
    logic               sign_step;
    logic [RADIX_W:0]   dig;
    logic [VAL_W-1:0]   lim;
    logic [SUM_W-1:0]   sum;
    logic [POS_W-1:0]   np;
    logic [POS_W+END_W-1:0] end_ext;
    logic               invalid_radix;

    assign first         = (pos_reg == '0);
    assign invalid_radix = (radix_set_reg == 6'd1) || (radix_set_reg > MAX_RADIX);
    assign np            = (pos_reg < POS_W'(MAX_LEN)) ? pos_reg + 1'b1 : POS_W'(MAX_LEN);

    assign status.last  = last_reg;
    assign status.first = first;

    always_comb
    begin
        phase_next   = first ? (invalid_radix ? PH_INVALID : PH_WS) : phase_reg;
        radix_next   = first ? radix_set_reg : radix_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        elim_next    = elim_reg;
        asp_next     = asp_reg;
        stop_next    = stop_reg;
        ovf_next     = ovf_reg;
        stopped_next = stopped_reg;
        used         = 1'b0;
        sign_step    = 1'b0;
        dig          = '0;
        sum          = '0;

        if (phase_next == PH_WS)
        begin
            if (is_white(char_reg))
            begin
                asp_next = np;
                used     = 1'b1;
            end
            else
                phase_next = PH_SIGN;
        end

        if (phase_next == PH_SIGN && !used)
        begin
            sign_step = 1'b1;
            if (char_reg == CH_MINUS)
            begin
                neg_next = 1'b1;
                used     = 1'b1;
            end
            else if (char_reg == CH_PLUS)
                used = 1'b1;
            elim_next = upper_reg;
            if (neg_next && upper_reg != '1)
                elim_next = upper_reg + 1'b1;
            phase_next = PH_PREFIX;
        end

        if (phase_next == PH_PREFIX && !used)
        begin
            if (radix_next == '0)
            begin
                if (char_reg == CH_ZERO)
                begin
                    radix_next = RADIX_8;
                    used       = 1'b1;
                    phase_next = PH_ZERO;
                end
                else if (char_reg == CH_LB)
                begin
                    radix_next = RADIX_2;
                    used       = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    radix_next = RADIX_10;
                    phase_next = PH_DIGITS;
                end
            end
            else
                phase_next = PH_DIGITS;
        end

        if (phase_next == PH_ZERO && !used)
        begin
            if (char_reg == CH_LX || char_reg == CH_UX)
            begin
                radix_next = RADIX_16;
                used       = 1'b1;
            end
            phase_next = PH_DIGITS;
        end

        // A fresh sign decision in this cycle is never negative here, and the
        // accumulator is still zero whenever the radix changes in this cycle.
        lim = sign_step ? upper_reg : elim_reg;
        if (phase_next == PH_DIGITS && !used)
        begin
            dig = digit_of(char_reg, radix_next);
            if (dig[RADIX_W])
            begin
                sum = SUM_W'(prod_reg) + SUM_W'(dig[RADIX_W-1:0]);
                if (sum > SUM_W'(lim))
                begin
                    ovf_next = 1'b1;
                    acc_next = '1;
                end
                else
                    acc_next = sum[VAL_W-1:0];
            end
            else
            begin
                stopped_next = 1'b1;
                stop_next    = pos_reg;
                phase_next   = PH_DONE;
            end
        end
    end

    always_comb
    begin
        value_next = raw_reg;
        err_next   = raw_err_reg;
        end_ext    = {{END_W{1'b0}}, raw_end_reg};
        end_next   = end_ext[END_W-1:0];
        if (signed_reg)
        begin
            if (raw_end_zero_reg)
                end_next = '0;
            priority if (neg_reg && raw_reg != '0 && !raw_reg[VAL_W-1])
            begin
                err_next   = 1'b1;
                value_next = SIGN_MIN;
            end
            else if (!neg_reg && raw_reg[VAL_W-1])
            begin
                err_next   = 1'b1;
                value_next = SIGN_MAX;
            end
            else if ($signed(raw_reg) < $signed(lower_reg))
            begin
                err_next   = 1'b1;
                value_next = SIGN_MIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_set_reg <= RADIX_10;
            upper_reg     <= '1;
            lower_reg     <= SIGN_MIN;
            signed_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIX:  radix_set_reg <= cfg_data[RADIX_W-1:0];
                CFG_UPPER:  upper_reg     <= cfg_data;
                CFG_LOWER:  lower_reg     <= cfg_data;
                CFG_SIGNED: signed_reg    <= cfg_data[0];
                default:    radix_set_reg <= radix_set_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WS;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            radix_reg   <= '0;
            elim_reg    <= '0;
            pos_reg     <= '0;
            asp_reg     <= '0;
            stop_reg    <= '0;
            ovf_reg     <= 1'b0;
            stopped_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                last_reg <= last_in;
            if (cmd.step)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                radix_reg   <= radix_next;
                elim_reg    <= elim_next;
                pos_reg     <= np;
                asp_reg     <= asp_next;
                stop_reg    <= stop_next;
                ovf_reg     <= ovf_next;
                stopped_reg <= stopped_next;
            end
            else if (cmd.emit)
            begin
                phase_reg   <= PH_WS;
                acc_reg     <= '0;
                neg_reg     <= 1'b0;
                radix_reg   <= '0;
                elim_reg    <= '0;
                pos_reg     <= '0;
                asp_reg     <= '0;
                stop_reg    <= '0;
                ovf_reg     <= 1'b0;
                stopped_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {{RADIX_W{1'b0}}, acc_reg} * {{VAL_W{1'b0}}, radix_reg};
        if (cmd.load)
            char_reg <= char_in;
        if (cmd.calc)
        begin
            if (phase_reg == PH_INVALID)
            begin
                raw_reg     <= '0;
                raw_err_reg <= 1'b0;
                raw_end_reg <= '0;
            end
            else
            begin
                raw_reg     <= neg_reg ? ('0 - acc_reg) : acc_reg;
                raw_err_reg <= ovf_reg;
                raw_end_reg <= stopped_reg ? stop_reg : pos_reg;
            end
            raw_end_zero_reg <= (phase_reg == PH_INVALID)
                                || ((stopped_reg ? stop_reg : pos_reg) == asp_reg);
        end
        if (cmd.emit)
        begin
            value_reg <= value_next;
            err_reg   <= err_next;
            end_reg   <= end_next;
        end
    end

    assign value        = value_reg;
    assign range_error  = err_reg;
    assign end_position = end_reg;

endmodule

[hdl/string_to_integer_parser.sv]
// Top level of the string to integer parser.
//
// Usage: characters arrive on s_axis, one Unicode code point per item in
// s_axis_tdata[20:0]; s_axis_tlast marks the final character of a string.
// Each string yields one result item on m_axis: value and end position in
// m_axis_tdata, the range error flag in m_axis_tuser.
// Configuration (radix, upper limit, lower limit, signed mode) is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while no
// string is in progress, as the block itself does not enforce this.
// Each character is taken in S_IDLE and applied to the parse state in S_EXEC
// before the input is ready again; after a last character the input also
// waits while S_FIN1 forms the raw result and S_FIN2 clamps it into the
// output register. The digit step is limited by the accumulate and overflow
// compare on the registered accumulator-times-radix product.
// Reset clears the parse state and sets radix 10, upper limit all ones,
// lower limit the signed minimum and unsigned mode.
// A stalled result register holds its item; the next string's characters
// are still taken, and only a following last character waits for it.
`timescale 1ns / 1ps
module string_to_integer_parser #(
    parameter int MAX_LEN = s2i_pkg::DEF_MAX_LEN
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [s2i_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // char_code
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [s2i_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // value, end_position
    output logic                                 m_axis_tuser,  // range_error
    input  logic                                 cfg_we,
    input  logic [s2i_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [s2i_pkg::VAL_W-1:0]            cfg_data
);
    import s2i_pkg::*;

    s2i_cmd_t          cmd;
    s2i_status_t       status;
    logic [VAL_W-1:0]  value;
    logic [END_W-1:0]  end_position;

    s2i_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    s2i_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_in      (s_axis_tdata[CHAR_W-1:0]),
        .last_in      (s_axis_tlast),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .range_error  (m_axis_tuser),
        .end_position (end_position)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-VAL_W-END_W){1'b0}}, end_position, value};

endmodule

[hdl/s2i_chk.sv]
// Port-level assertions for the string to integer parser, bound to the top level.
`timescale 1ns / 1ps
module s2i_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [s2i_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser
);
    import s2i_pkg::*;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_char_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("item taken on back-to-back cycles");

    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened before the result was formed");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared outside the finish sequence");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind string_to_integer_parser s2i_chk u_s2i_chk (.*);
